[hdl/rkw_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rkw_pkg
// Shared constants and types for the RC4 keystream window block.
// -----------------------------------------------------------------------------
package rkw_pkg;

   localparam int WIN_BYTES = 4096;
   localparam int WIN_AW    = $clog2(WIN_BYTES);
   localparam int STORE_AW  = WIN_AW + 1;
   localparam int PERM_AW   = 8;
   localparam int POS_W     = 64;
   localparam int KEY_W     = 64;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b1;

   localparam logic [7:0] KS_INVERT = 8'hff;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_K_INIT,
      ST_K_RN,
      ST_K_RJ,
      ST_K_WN,
      ST_K_WJ,
      ST_G_RI,
      ST_G_RJ,
      ST_G_WI,
      ST_G_WJ,
      ST_G_RO,
      ST_G_ST,
      ST_LOOK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               we;
      logic [PERM_AW-1:0] addr;
      logic [7:0]         wdata;
   } perm_req_type;

   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          wdata;
   } store_req_type;

endpackage

[hdl/rkw_ram.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rkw_ram
// Single-port synchronous RAM, registered read data.
// -----------------------------------------------------------------------------
module rkw_ram #(
   parameter int AW = 8,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/rc4_keystream_window_xor_top.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rc4_keystream_window_xor_top
// RC4 generator feeding transmit and receive keystream windows, byte XOR.
// -----------------------------------------------------------------------------
// One byte is handled at a time. A byte already inside its window passes the
// evaluate, lookup and output states. Each keystream byte that must be made
// adds read i, read j, write i, write j, read output, store and recheck, set by
// the single port of the 256-entry permutation RAM. After reset or a key write
// the first generation first runs the key schedule: an identity fill of all 256
// entries, then read n, read j, write n, write j per entry. A result register
// lets the next byte be accepted while the previous result is still stalled.
// -----------------------------------------------------------------------------
module rc4_keystream_window_xor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_direction,
   input  logic [rkw_pkg::POS_W-1:0]      req_position,
   input  logic [7:0]                     req_data_in,
   input  logic                           req_segment_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_data_out,
   output logic                           rsp_out_of_window,
   output logic                           rsp_last_out,
   input  logic                           csr_write_en,
   input  logic [rkw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rkw_pkg::KEY_W-1:0]      csr_wdata
);

   rkw_pkg::state_type state_ff, state_in;

   logic [rkw_pkg::KEY_W-1:0] key_low_ff, key_high_ff;
   logic                      stale_ff;
   logic [7:0]                i_ff, j_ff, n_ff, a_ff, b_ff;

   logic                         dir_ff;
   logic [rkw_pkg::POS_W-1:0]    pos_ff;
   logic [7:0]                   data_ff;
   logic                         last_ff;
   logic                         flag_ff;

   logic                         started_ff [2];
   logic [rkw_pkg::POS_W-1:0]    start_ff   [2];
   logic [rkw_pkg::POS_W-1:0]    end_ff     [2];
   logic [rkw_pkg::WIN_AW-1:0]   head_ff    [2];
   logic [rkw_pkg::WIN_AW-1:0]   tail_ff    [2];

   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_data_ff;
   logic                         rsp_flag_ff;
   logic                         rsp_last_ff;

   rkw_pkg::perm_req_type        perm_req;
   rkw_pkg::store_req_type       store_req;
   logic [7:0]                   perm_rdata, store_rdata;

   logic                         accept;
   logic                         out_fire;
   logic [rkw_pkg::POS_W:0]      end_diff;
   logic                         pos_ge_end, pos_far;
   logic [rkw_pkg::POS_W:0]      start_diff;
   logic                         pos_lt_start;
   logic [rkw_pkg::POS_W-1:0]    span;
   logic                         win_full;
   logic [7:0]                   key_byte;
   logic [2*rkw_pkg::KEY_W-1:0]  key_all;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != rkw_pkg::ST_IDLE);
   assign out_fire = (state_ff == rkw_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign end_diff     = {1'b0, pos_ff} - {1'b0, end_ff[dir_ff]};
   assign pos_ge_end   = !end_diff[rkw_pkg::POS_W];
   assign pos_far      = pos_ge_end && (|end_diff[rkw_pkg::POS_W-1:rkw_pkg::WIN_AW]);
   assign start_diff   = {1'b0, pos_ff} - {1'b0, start_ff[dir_ff]};
   assign pos_lt_start = start_diff[rkw_pkg::POS_W];
   assign span         = end_ff[dir_ff] - start_ff[dir_ff];
   assign win_full     = |span[rkw_pkg::POS_W-1:rkw_pkg::WIN_AW];
   assign key_all      = {key_high_ff, key_low_ff};
   assign key_byte     = key_all[n_ff[3:0]*8 +: 8];

   rkw_ram #(.AW(rkw_pkg::PERM_AW), .DW(8)) u_perm (
      .clock (clock),
      .we    (perm_req.we),
      .addr  (perm_req.addr),
      .wdata (perm_req.wdata),
      .rdata (perm_rdata)
   );

   rkw_ram #(.AW(rkw_pkg::STORE_AW), .DW(8)) u_store (
      .clock (clock),
      .we    (store_req.we),
      .addr  (store_req.addr),
      .wdata (store_req.wdata),
      .rdata (store_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rkw_pkg::ST_IDLE:   if (accept) state_in = rkw_pkg::ST_EVAL;
         rkw_pkg::ST_EVAL: begin
            if (pos_far) begin
               state_in = rkw_pkg::ST_OUT;
            end else if (pos_ge_end) begin
               state_in = stale_ff ? rkw_pkg::ST_K_INIT : rkw_pkg::ST_G_RI;
            end else begin
               state_in = rkw_pkg::ST_LOOK;
            end
         end
         rkw_pkg::ST_K_INIT: if (n_ff == 8'hff) state_in = rkw_pkg::ST_K_RN;
         rkw_pkg::ST_K_RN:   state_in = rkw_pkg::ST_K_RJ;
         rkw_pkg::ST_K_RJ:   state_in = rkw_pkg::ST_K_WN;
         rkw_pkg::ST_K_WN:   state_in = rkw_pkg::ST_K_WJ;
         rkw_pkg::ST_K_WJ: begin
            state_in = (n_ff == 8'hff) ? rkw_pkg::ST_G_RI : rkw_pkg::ST_K_RN;
         end
         rkw_pkg::ST_G_RI:   state_in = rkw_pkg::ST_G_RJ;
         rkw_pkg::ST_G_RJ:   state_in = rkw_pkg::ST_G_WI;
         rkw_pkg::ST_G_WI:   state_in = rkw_pkg::ST_G_WJ;
         rkw_pkg::ST_G_WJ:   state_in = rkw_pkg::ST_G_RO;
         rkw_pkg::ST_G_RO:   state_in = rkw_pkg::ST_G_ST;
         rkw_pkg::ST_G_ST:   state_in = rkw_pkg::ST_EVAL;
         rkw_pkg::ST_LOOK:   state_in = rkw_pkg::ST_OUT;
         rkw_pkg::ST_OUT:    if (out_fire) state_in = rkw_pkg::ST_IDLE;
         default:            state_in = rkw_pkg::ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      perm_req  = '0;
      store_req = '0;
      case (state_ff)
         rkw_pkg::ST_K_INIT: begin
            perm_req.we    = 1'b1;
            perm_req.addr  = n_ff;
            perm_req.wdata = n_ff;
         end
         rkw_pkg::ST_K_RN: perm_req.addr = n_ff;
         rkw_pkg::ST_K_RJ: perm_req.addr = j_ff + perm_rdata + key_byte;
         rkw_pkg::ST_K_WN: begin
            perm_req.we    = 1'b1;
            perm_req.addr  = n_ff;
            perm_req.wdata = perm_rdata;
         end
         rkw_pkg::ST_K_WJ: begin
            perm_req.we    = 1'b1;
            perm_req.addr  = j_ff;
            perm_req.wdata = a_ff;
         end
         rkw_pkg::ST_G_RI: perm_req.addr = i_ff + 8'd1;
         rkw_pkg::ST_G_RJ: perm_req.addr = j_ff + perm_rdata;
         rkw_pkg::ST_G_WI: begin
            perm_req.we    = 1'b1;
            perm_req.addr  = i_ff;
            perm_req.wdata = perm_rdata;
         end
         rkw_pkg::ST_G_WJ: begin
            perm_req.we    = 1'b1;
            perm_req.addr  = j_ff;
            perm_req.wdata = a_ff;
         end
         rkw_pkg::ST_G_RO: perm_req.addr = a_ff + b_ff;
         rkw_pkg::ST_G_ST: begin
            store_req.we    = 1'b1;
            store_req.addr  = {dir_ff, tail_ff[dir_ff]};
            store_req.wdata = perm_rdata ^ rkw_pkg::KS_INVERT;
         end
         // address held through the output wait so the read data stays put
         rkw_pkg::ST_LOOK, rkw_pkg::ST_OUT: begin
            store_req.addr = {dir_ff,
                              head_ff[dir_ff] + start_diff[rkw_pkg::WIN_AW-1:0]};
         end
         default: begin
            perm_req  = '0;
            store_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rkw_pkg::ST_IDLE;
         stale_ff      <= 1'b1;
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         n_ff          <= '0;
         started_ff[0] <= 1'b0;
         started_ff[1] <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write_en) begin
            stale_ff <= 1'b1;
            case (csr_index)
               rkw_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
               rkw_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
               default:               key_low_ff  <= key_low_ff;
            endcase
         end

         if (accept) begin
            dir_ff  <= req_direction;
            pos_ff  <= req_position;
            data_ff <= req_data_in;
            last_ff <= req_segment_last;
            flag_ff <= 1'b0;
            if (!started_ff[req_direction]) begin
               started_ff[req_direction] <= 1'b1;
               start_ff[req_direction]   <= req_position;
               end_ff[req_direction]     <= req_position;
               head_ff[req_direction]    <= '0;
               tail_ff[req_direction]    <= '0;
            end
         end

         case (state_ff)
            rkw_pkg::ST_EVAL: if (pos_far) flag_ff <= 1'b1;
            rkw_pkg::ST_K_INIT: begin
               n_ff <= n_ff + 8'd1;
               j_ff <= '0;
            end
            rkw_pkg::ST_K_RJ: begin
               a_ff <= perm_rdata;
               j_ff <= j_ff + perm_rdata + key_byte;
            end
            rkw_pkg::ST_K_WJ: begin
               n_ff <= n_ff + 8'd1;
               if (n_ff == 8'hff) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  stale_ff <= 1'b0;
               end
            end
            rkw_pkg::ST_G_RI: i_ff <= i_ff + 8'd1;
            rkw_pkg::ST_G_RJ: begin
               a_ff <= perm_rdata;
               j_ff <= j_ff + perm_rdata;
            end
            rkw_pkg::ST_G_WI: b_ff <= perm_rdata;
            rkw_pkg::ST_G_ST: begin
               tail_ff[dir_ff] <= tail_ff[dir_ff] + 1'b1;
               end_ff[dir_ff]  <= end_ff[dir_ff] + 1'b1;
               if (win_full) begin
                  head_ff[dir_ff]  <= head_ff[dir_ff] + 1'b1;
                  start_ff[dir_ff] <= start_ff[dir_ff] + 1'b1;
               end
            end
            rkw_pkg::ST_LOOK: if (pos_lt_start) flag_ff <= 1'b1;
            default: n_ff <= n_ff;
         endcase

         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= flag_ff ? data_ff : (data_ff ^ store_rdata);
            rsp_flag_ff  <= flag_ff;
            rsp_last_ff  <= last_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_out_of_window = rsp_flag_ff;
   assign rsp_last_out      = rsp_last_ff;

   a_gen_fresh: assert property (@(posedge clock) disable iff (reset)
      state_ff == rkw_pkg::ST_G_RI |-> !stale_ff)
      else $error("keystream generated with stale schedule");

   a_end_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == rkw_pkg::ST_G_ST |=> end_ff[dir_ff] == $past(end_ff[dir_ff]) + 64'd1)
      else $error("window end did not advance");

   a_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rkw_pkg::ST_EVAL && started_ff[dir_ff])
      |-> span <= 64'(rkw_pkg::WIN_BYTES))
      else $error("window span exceeds capacity");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == rkw_pkg::ST_EVAL && started_ff[dir_ff])
      else $error("accepted word not anchored");

endmodule
